// ===== src/lsfl_pkg.sv =====
// shared types and codes for the linked stack with free list
package lsfl_pkg;

   // operation codes on req_func
   localparam logic [1:0] FUNC_PUSH = 2'd0;
   localparam logic [1:0] FUNC_POP  = 2'd1;
   localparam logic [1:0] FUNC_PEEK = 2'd2;

   // result status codes on rsp_status
   localparam logic [1:0] STAT_OK    = 2'd0;
   localparam logic [1:0] STAT_FULL  = 2'd1;
   localparam logic [1:0] STAT_EMPTY = 2'd2;

   // controller to datapath
   typedef struct packed {
      logic capture;   // transaction taken, latch operands and start reads
      logic sel_free;  // link read follows the free list head
      logic commit;    // update heads and node store
      logic do_push;
      logic do_pop;
   } lsfl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic full;
      logic empty;
   } lsfl_stat_type;

endpackage

// ===== src/lsfl_ram.sv =====
// generic single write port, single read port ram with registered read
module lsfl_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/lsfl_ctrl.sv =====
// controller state machine: handshakes, operation sequencing and result status
module lsfl_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [1:0]             req_func,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [1:0]             rsp_status,
   output lsfl_pkg::lsfl_cmd_type cmd,
   input  lsfl_pkg::lsfl_stat_type stat
);

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } state_type;

   state_type  state_ff, state_in;
   logic       op_push_ff, op_push_in;
   logic       op_pop_ff, op_pop_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [1:0] rsp_status_ff, rsp_status_in;
   logic       take;
   logic       commit;
   logic       dec_push;
   logic       dec_pop;

   always_comb begin
      dec_push = 1'b0;
      dec_pop  = 1'b0;
      case (req_func)
         lsfl_pkg::FUNC_PUSH: dec_push = 1'b1;
         lsfl_pkg::FUNC_POP:  dec_pop  = 1'b1;
         default:             ;
      endcase
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign take      = req_valid && req_ready;
   assign commit    = (state_ff == ST_EXEC) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      state_in      = state_ff;
      op_push_in    = op_push_ff;
      op_pop_in     = op_pop_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      case (state_ff)
         ST_IDLE: begin
            if (take) begin
               op_push_in = dec_push;
               op_pop_in  = dec_pop;
               state_in   = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (commit) begin
               rsp_valid_in = 1'b1;
               if (op_push_ff) begin
                  rsp_status_in = stat.full ? lsfl_pkg::STAT_FULL : lsfl_pkg::STAT_OK;
               end else begin
                  rsp_status_in = stat.empty ? lsfl_pkg::STAT_EMPTY : lsfl_pkg::STAT_OK;
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_push_ff    <= op_push_in;
      op_pop_ff     <= op_pop_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign cmd.capture  = take;
   assign cmd.sel_free = dec_push;
   assign cmd.commit   = commit;
   assign cmd.do_push  = op_push_ff && !stat.full;
   assign cmd.do_pop   = op_pop_ff && !stat.empty;

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;

endmodule

// ===== src/lsfl_datapath.sv =====
// datapath: list heads, cached top, node store and link resolution
module lsfl_datapath #(
   parameter int DEPTH       = 8,
   parameter int VALUE_WIDTH = 32
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic signed [31:0]      req_push_value,
   output logic signed [31:0]      rsp_top_value,
   output logic                    rsp_stack_empty,
   input  lsfl_pkg::lsfl_cmd_type  cmd,
   output lsfl_pkg::lsfl_stat_type stat
);

   localparam int IDX_W = $clog2(DEPTH);
   localparam int PTR_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] NULL_PTR = PTR_W'(DEPTH);

   logic [PTR_W-1:0]       free_head_ff, free_head_in;
   logic [PTR_W-1:0]       stack_head_ff, stack_head_in;
   logic [PTR_W-1:0]       second_ff, second_in;       // node below the top
   logic [PTR_W-1:0]       fill_ff, fill_in;           // nodes below this never linked
   logic [VALUE_WIDTH-1:0] top_ff, top_in;
   logic [VALUE_WIDTH-1:0] pv_ff;
   logic                   use_dflt_ff;

   logic                   free_ok;
   logic                   stack_ok;
   logic [PTR_W-1:0]       rd_ptr;
   logic [PTR_W-1:0]       link_rd;
   logic [PTR_W-1:0]       link_dflt;
   logic [PTR_W-1:0]       link_eff;
   logic [VALUE_WIDTH-1:0] val_rd;
   logic                   nx_wr;
   logic [IDX_W-1:0]       nx_wr_addr;
   logic [PTR_W-1:0]       nx_wr_data;
   logic [63:0]            top_wide;

   assign free_ok  = free_head_ff < NULL_PTR;
   assign stack_ok = stack_head_ff < NULL_PTR;

   assign stat.full  = !free_ok;
   assign stat.empty = !stack_ok;

   // push follows the free list, everything else the node under the top
   assign rd_ptr = cmd.sel_free ? free_head_ff : second_ff;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         pv_ff       <= VALUE_WIDTH'(req_push_value);
         use_dflt_ff <= cmd.sel_free && (free_head_ff < fill_ff);
      end
   end

   lsfl_ram #(
      .WIDTH (PTR_W),
      .DEPTH (DEPTH)
   ) u_next_ram (
      .clock   (clock),
      .wr_en   (nx_wr),
      .wr_addr (nx_wr_addr),
      .wr_data (nx_wr_data),
      .rd_en   (cmd.capture),
      .rd_addr (rd_ptr[IDX_W-1:0]),
      .rd_data (link_rd)
   );

   lsfl_ram #(
      .WIDTH (VALUE_WIDTH),
      .DEPTH (DEPTH)
   ) u_value_ram (
      .clock   (clock),
      .wr_en   (cmd.commit && cmd.do_push),
      .wr_addr (free_head_ff[IDX_W-1:0]),
      .wr_data (pv_ff),
      .rd_en   (cmd.capture),
      .rd_addr (second_ff[IDX_W-1:0]),
      .rd_data (val_rd)
   );

   // untouched nodes read as their reset chain link, worked out from the free head
   assign link_dflt = (free_head_ff == '0) ? NULL_PTR : free_head_ff - PTR_W'(1);
   assign link_eff  = use_dflt_ff ? link_dflt : link_rd;

   always_comb begin
      free_head_in  = free_head_ff;
      stack_head_in = stack_head_ff;
      second_in     = second_ff;
      fill_in       = fill_ff;
      top_in        = top_ff;
      nx_wr         = 1'b0;
      nx_wr_addr    = free_head_ff[IDX_W-1:0];
      nx_wr_data    = stack_head_ff;
      if (cmd.commit && cmd.do_push) begin
         nx_wr         = 1'b1;
         free_head_in  = link_eff;
         stack_head_in = free_head_ff;
         second_in     = stack_head_ff;
         top_in        = pv_ff;
         if (use_dflt_ff) begin
            fill_in = free_head_ff;
         end
      end else if (cmd.commit && cmd.do_pop) begin
         nx_wr         = 1'b1;
         nx_wr_addr    = stack_head_ff[IDX_W-1:0];
         nx_wr_data    = free_head_ff;
         free_head_in  = stack_head_ff;
         stack_head_in = second_ff;
         second_in     = link_eff;
         top_in        = val_rd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         free_head_ff  <= PTR_W'(DEPTH - 1);
         stack_head_ff <= NULL_PTR;
         second_ff     <= NULL_PTR;
         fill_ff       <= NULL_PTR;
      end else begin
         free_head_ff  <= free_head_in;
         stack_head_ff <= stack_head_in;
         second_ff     <= second_in;
         fill_ff       <= fill_in;
      end
      top_ff <= top_in;
   end

   assign top_wide        = 64'(signed'(top_ff));
   assign rsp_top_value   = stack_ok ? signed'(top_wide[31:0]) : '0;
   assign rsp_stack_empty = !stack_ok;

endmodule

// ===== src/linked_stack_with_free_list.sv =====
// top level of the linked stack with free list
//
//  channel  direction  ports                                         transaction
//  req      in         req_valid req_ready req_func req_push_value   one operation
//  rsp      out        rsp_valid rsp_ready rsp_status                one result
//                      rsp_top_value rsp_stack_empty
//
// each operation is an accept plus node store read, then a commit of heads
// and links; the commit follows the registered read of the node store
// reset is synchronous; the free list starts chained from DEPTH-1 down to 0
// with no clearing pass, untouched nodes being tracked by a fill count
// a new transaction is taken while a result still waits; the commit of that
// transaction holds until the result register is free
module linked_stack_with_free_list #(
   parameter int DEPTH       = 8,
   parameter int VALUE_WIDTH = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_func,
   input  logic signed [31:0] req_push_value,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [1:0]         rsp_status,
   output logic signed [31:0] rsp_top_value,
   output logic               rsp_stack_empty
);

   // command and status between controller and datapath
   lsfl_pkg::lsfl_cmd_type  cmd;
   lsfl_pkg::lsfl_stat_type stat;

   // sequencing, handshakes and status code
   lsfl_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_func   (req_func),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_status (rsp_status),
      .cmd        (cmd),
      .stat       (stat)
   );

   // heads, cached top value and the node store
   lsfl_datapath #(
      .DEPTH       (DEPTH),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .req_push_value  (req_push_value),
      .rsp_top_value   (rsp_top_value),
      .rsp_stack_empty (rsp_stack_empty),
      .cmd             (cmd),
      .stat            (stat)
   );

endmodule

// ===== tb/linked_stack_with_free_list_tb.sv =====
// testbench for the linked stack with free list, checked against a shadow stack
`timescale 1ns / 1ps

module linked_stack_with_free_list_tb;

   localparam int STACK_DEPTH = 8;
   localparam int IDX_W = $clog2(STACK_DEPTH);
   localparam logic [3:0] NIL_LINK = 4'(STACK_DEPTH);   // index that names no node
   localparam logic [1:0] FUNC_SPARE = 2'd3;            // unused selector, behaves as a peek
   localparam int STALL_LIMIT = 5000;                   // cycles with no transaction at all

   // one expected result transaction
   typedef struct packed {
      logic [1:0]         status;
      logic signed [31:0] top_value;
      logic               stack_empty;
   } stack_result_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [1:0]         req_func = lsfl_pkg::FUNC_PUSH;
   logic signed [31:0] req_push_value = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [1:0]         rsp_status;
   logic signed [31:0] rsp_top_value;
   logic               rsp_stack_empty;

   // idling switches for sender and receiver, both off for the closing stretch
   logic src_idle_en = 1'b1;
   logic sink_idle_en = 1'b1;
   int   sink_burst = 0;

   int error_count = 0;
   int quiet_cycles = 0;

   // shadow copy of the node store and both list heads
   logic [31:0] node_word [STACK_DEPTH];
   logic [3:0]  node_link [STACK_DEPTH];
   logic [3:0]  free_top;
   logic [3:0]  stack_top;

   // results still owed by the block, oldest first
   stack_result_type expected_results[$];

   linked_stack_with_free_list dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_func        (req_func),
      .req_push_value  (req_push_value),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_top_value   (rsp_top_value),
      .rsp_stack_empty (rsp_stack_empty)
   );

   // 4 ns clock
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // free list chained from the highest node down to node 0, stack empty
   task automatic reset_shadow();
      for (int i = 0; i < STACK_DEPTH; i++) begin
         node_word[IDX_W'(i)] = '0;
         node_link[IDX_W'(i)] = (i == 0) ? NIL_LINK : 4'(i - 1);
      end
      free_top = 4'(STACK_DEPTH - 1);
      stack_top = NIL_LINK;
   endtask

   function automatic logic is_node(logic [3:0] idx);
      return idx < STACK_DEPTH;
   endfunction

   // apply one operation to the shadow stack and give the result it must produce
   function automatic stack_result_type apply_stack_op(logic [1:0] op, logic [31:0] value);
      stack_result_type res;
      logic [3:0]       node;
      logic [1:0]       code;
      code = lsfl_pkg::STAT_OK;
      if (op == lsfl_pkg::FUNC_PUSH) begin
         if (!is_node(free_top)) begin
            // free list exhausted, push refused
            code = lsfl_pkg::STAT_FULL;
         end else begin
            node = free_top;
            free_top = is_node(node_link[node[IDX_W-1:0]]) ? node_link[node[IDX_W-1:0]]
                                                           : NIL_LINK;
            node_word[node[IDX_W-1:0]] = value;
            node_link[node[IDX_W-1:0]] = is_node(stack_top) ? stack_top : NIL_LINK;
            stack_top = node;
         end
      end else if (!is_node(stack_top)) begin
         // pop, peek or the spare code on an empty stack
         stack_top = NIL_LINK;
         code = lsfl_pkg::STAT_EMPTY;
      end else if (op == lsfl_pkg::FUNC_POP) begin
         node = stack_top;
         stack_top = is_node(node_link[node[IDX_W-1:0]]) ? node_link[node[IDX_W-1:0]]
                                                         : NIL_LINK;
         node_link[node[IDX_W-1:0]] = is_node(free_top) ? free_top : NIL_LINK;
         free_top = node;
      end
      res.status = code;
      res.stack_empty = !is_node(stack_top);
      res.top_value = res.stack_empty ? '0 : node_word[stack_top[IDX_W-1:0]];
      return res;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
      $display("%0t mismatch on %s: expected %h, got %h", $realtime, what, want, got);
      error_count++;
   endtask

   // drive one operation, hold it until taken, then maybe leave a gap
   task automatic send_op(logic [1:0] op, logic [31:0] value);
      int gap;
      req_valid <= 1'b1;
      req_func <= op;
      req_push_value <= value;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      expected_results.push_back(apply_stack_op(op, value));
      if (src_idle_en && $urandom_range(0, 2) == 0) begin
         gap = $urandom_range(1, 14);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // receiver: ready held high or low in random bursts, or high throughout once idling is off
   always @(posedge clock) begin
      if (!sink_idle_en) begin
         rsp_ready <= 1'b1;
      end else if (sink_burst > 0) begin
         sink_burst--;
      end else begin
         sink_burst = $urandom_range(1, 14);
         rsp_ready <= ($urandom_range(0, 2) != 0);
      end
   end

   // each result transaction against the oldest expectation
   always @(posedge clock) begin
      stack_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_results.size() == 0) begin
            report_mismatch("unexpected result", '0, rsp_top_value);
         end else begin
            want = expected_results.pop_front();
            if (rsp_status !== want.status)
               report_mismatch("status", 32'(want.status), 32'(rsp_status));
            if (rsp_top_value !== want.top_value)
               report_mismatch("top_value", want.top_value, rsp_top_value);
            if (rsp_stack_empty !== want.stack_empty)
               report_mismatch("stack_empty", 32'(want.stack_empty), 32'(rsp_stack_empty));
         end
      end
   end

   // watchdog: too long without any transaction on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles + 1 >= STALL_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
         end
      end
   end

   // pop, peek and the spare code straight after reset
   task automatic test_empty_refusals();
      send_op(lsfl_pkg::FUNC_PEEK, 32'h0000_0000);
      send_op(lsfl_pkg::FUNC_POP, 32'hFFFF_FFFF);
      send_op(FUNC_SPARE, 32'h1234_5678);
   endtask

   // fill every node with edge values, push once more while full, then peek and the spare code
   task automatic test_fill_past_full();
      logic [31:0] edge_values [STACK_DEPTH];
      edge_values = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF,
                      32'h0000_0001, 32'h5555_5555, 32'hAAAA_AAAA, 32'hFFFF_FFFE};
      for (int i = 0; i < STACK_DEPTH; i++)
         send_op(lsfl_pkg::FUNC_PUSH, edge_values[IDX_W'(i)]);
      send_op(lsfl_pkg::FUNC_PUSH, 32'hDEAD_BEEF);
      send_op(lsfl_pkg::FUNC_PEEK, 32'h0);
      send_op(FUNC_SPARE, 32'hFFFF_FFFF);
   endtask

   // unwind the full stack and pop once more while empty
   task automatic test_drain_past_empty();
      for (int i = 0; i <= STACK_DEPTH; i++)
         send_op(lsfl_pkg::FUNC_POP, $urandom());
   endtask

   // mixed operations; the push share swings so the stack fills and empties
   task automatic test_random_traffic(int count);
      int          push_pct;
      int          roll;
      logic [1:0]  op;
      logic [31:0] value;
      push_pct = 50;
      for (int i = 0; i < count; i++) begin
         if (i % 24 == 0)
            push_pct = 25 * $urandom_range(1, 3);
         roll = $urandom_range(0, 99);
         if (roll < push_pct)
            op = lsfl_pkg::FUNC_PUSH;
         else if (roll < 88)
            op = lsfl_pkg::FUNC_POP;
         else if (roll < 95)
            op = lsfl_pkg::FUNC_PEEK;
         else
            op = FUNC_SPARE;
         case ($urandom_range(0, 15))
            0: value = 32'h8000_0000;
            1: value = 32'h7FFF_FFFF;
            default: value = $urandom();
         endcase
         send_op(op, value);
      end
   endtask

   // four pushes, then the sender holds off until every owed result has arrived, then a peek
   task automatic test_pause_until_drained();
      for (int i = 0; i < 4; i++)
         send_op(lsfl_pkg::FUNC_PUSH, $urandom());
      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      send_op(lsfl_pkg::FUNC_PEEK, $urandom());
   endtask

   // closing stretch with no idling on either side
   task automatic test_back_to_back(int count);
      src_idle_en <= 1'b0;
      sink_idle_en <= 1'b0;
      test_random_traffic(count);
   endtask

   initial begin
      reset_shadow();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_empty_refusals();
      test_fill_past_full();
      test_drain_past_empty();
      test_random_traffic(700);
      test_pause_until_drained();
      test_random_traffic(700);
      test_back_to_back(200);

      // let the last results come back, then a short settling tail
      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (error_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
src/lsfl_pkg.sv
src/lsfl_ram.sv
src/lsfl_ctrl.sv
src/lsfl_datapath.sv
src/linked_stack_with_free_list.sv
tb/linked_stack_with_free_list_tb.sv
